@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the queue manager RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lqm_pkg.sv @@
// ---------------------------------------------------------------------------
// lqm_pkg
// Types and constants shared by the linked list queue manager modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lqm_pkg;

   // Pool geometry
   localparam int SLOTS    = 16;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int LINK_W   = $clog2(SLOTS + 1);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int TAG_BITS = 3;

   // Beat field widths
   localparam int SLOT_IN_W = 4;
   localparam int TAG_IN_W  = 3;
   localparam int DATA_W    = 8;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
   localparam logic [DATA_W-1:0] ERR_DATA  = 8'hFF;

   typedef enum logic {
      FUNC_APPEND = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_UNLINKED = 2'd2,
      ST_REFUSED  = 2'd3
   } status_type;

   typedef struct packed {
      func_type               func;
      logic [SLOT_IN_W-1:0]   slot;
      logic [DATA_W-1:0]      payload;
      logic [TAG_IN_W-1:0]    tag;
   } op_type;

   typedef struct packed {
      status_type             status;
      logic [DATA_W-1:0]      removed_data;
      logic [CNT_W-1:0]       count;
      logic [LINK_W-1:0]      first_slot;
   } rsp_type;

endpackage

@@ hw/rtl/linked_list_queue_manager.sv @@
// ---------------------------------------------------------------------------
// linked_list_queue_manager
// Doubly linked list queue over a fixed slot pool: append at tail, remove any.
// ---------------------------------------------------------------------------
// Sustains one operation per clock while the response side drains: a beat is
// captured in the input register; when the output register is free or being
// drained, the append or remove is applied to the slot link arrays and the
// response lands in the output register at the same edge. The update touches
// only the slot and its two neighbors in flop-based arrays.
// The output register holds a response while the next request is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linked_list_queue_manager
   import lqm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [SLOT_IN_W-1:0]  req_slot,
   input  logic [DATA_W-1:0]     req_payload,
   input  logic [TAG_IN_W-1:0]   req_tag,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [DATA_W-1:0]     rsp_removed_data,
   output logic [CNT_W-1:0]      rsp_count,
   output logic [LINK_W-1:0]     rsp_first_slot
);

   op_type  op_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, core_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    fire;

   // Stage advance when the output register is free or being drained
   always_comb begin
      fire         = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || fire;
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response beats
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff.func    <= func_type'(req_func);
         op_ff.slot    <= req_slot;
         op_ff.payload <= req_payload;
         op_ff.tag     <= req_tag;
      end
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   lqm_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .op    (op_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_removed_data = rsp_ff.removed_data;
   assign rsp_count        = rsp_ff.count;
   assign rsp_first_slot   = rsp_ff.first_slot;

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset,
      req_valid && req_ready && in_valid_ff, fire, "request beat overwrote a pending one")
   `ASSERT_IMPLIES(a_ready_when_free, clock, reset,
      !in_valid_ff, req_ready, "input register free but request not ready")
   `ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid_ff && !rsp_ready, rsp_valid_ff, "response beat dropped before accept")

endmodule

@@ hw/rtl/lqm_core.sv @@
// ---------------------------------------------------------------------------
// lqm_core
// Link arrays, head/tail/size and the single-pass append/remove update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lqm_core
   import lqm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  op_type  op,
   output rsp_type rsp
);

   // Per-slot state
   logic [LINK_W-1:0]   prev_ff  [SLOTS];
   logic [LINK_W-1:0]   next_ff  [SLOTS];
   logic [TAG_BITS-1:0] owner_ff [SLOTS];
   logic [DATA_W-1:0]   data_ff  [SLOTS];

   // List pointers
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  size_ff, size_in;

   logic [SLOT_W-1:0]   sidx;
   logic [LINK_W-1:0]   slot_link;
   logic                in_range;
   logic                owned;
   logic [LINK_W-1:0]   cur_prev, cur_next;
   logic [TAG_BITS-1:0] new_owner;

   // Write ports: the slot itself, prev of its successor, next of its predecessor
   logic                wr_self, wr_data;
   logic [LINK_W-1:0]   self_prev, self_next;
   logic [TAG_BITS-1:0] self_owner;
   logic                wr_pn, wr_nn;
   logic [SLOT_W-1:0]   pn_addr, nn_addr;
   logic [LINK_W-1:0]   pn_val, nn_val;

   status_type          status;
   logic [DATA_W-1:0]   rdata;

   // Operation decode and list update
   always_comb begin
      sidx      = SLOT_W'(op.slot);
      slot_link = LINK_W'(sidx);
      in_range  = (32'(op.slot) < SLOTS);
      new_owner = TAG_BITS'(op.tag);
      cur_prev  = prev_ff[sidx];
      cur_next  = next_ff[sidx];
      owned     = in_range && (owner_ff[sidx] != '0);

      status     = ST_OK;
      rdata      = ERR_DATA;
      head_in    = head_ff;
      tail_in    = tail_ff;
      size_in    = size_ff;
      wr_self    = 1'b0;
      wr_data    = 1'b0;
      self_prev  = NULL_LINK;
      self_next  = NULL_LINK;
      self_owner = '0;
      wr_pn      = 1'b0;
      pn_addr    = SLOT_W'(cur_next);
      pn_val     = NULL_LINK;
      wr_nn      = 1'b0;
      nn_addr    = SLOT_W'(cur_prev);
      nn_val     = NULL_LINK;

      case (op.func)
         FUNC_APPEND: begin
            if (!in_range || new_owner == '0 || owned) begin
               status = ST_REFUSED;
            end else begin
               wr_self    = 1'b1;
               wr_data    = 1'b1;
               self_owner = new_owner;
               self_next  = NULL_LINK;
               if (size_ff == '0 || tail_ff >= NULL_LINK) begin
                  self_prev = NULL_LINK;
                  head_in   = slot_link;
               end else begin
                  self_prev = tail_ff;
                  wr_nn     = 1'b1;
                  nn_addr   = SLOT_W'(tail_ff);
                  nn_val    = slot_link;
               end
               tail_in = slot_link;
               size_in = size_ff + 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (size_ff == '0) begin
               status = ST_EMPTY;
            end else if (!owned) begin
               status = ST_UNLINKED;
            end else begin
               // only entry, head, tail or middle
               if (size_ff == CNT_W'(1)) begin
                  head_in = NULL_LINK;
                  tail_in = NULL_LINK;
               end else if (slot_link == head_ff) begin
                  head_in = cur_next;
                  wr_pn   = (cur_next < NULL_LINK);
                  pn_val  = NULL_LINK;
               end else if (slot_link == tail_ff) begin
                  tail_in = cur_prev;
                  wr_nn   = (cur_prev < NULL_LINK);
                  nn_val  = NULL_LINK;
               end else begin
                  wr_pn  = (cur_next < NULL_LINK);
                  pn_val = cur_prev;
                  wr_nn  = (cur_prev < NULL_LINK);
                  nn_val = cur_next;
               end
               size_in = size_ff - 1'b1;
               rdata   = data_ff[sidx];
               wr_self = 1'b1;
            end
         end
         default: begin
            status = ST_REFUSED;
         end
      endcase

      rsp.status       = status;
      rsp.removed_data = rdata;
      rsp.count        = size_in;
      rsp.first_slot   = head_in;
   end

   // Links, owners and pointers; the slot's own write wins over a neighbor write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            prev_ff[i]  <= NULL_LINK;
            next_ff[i]  <= NULL_LINK;
            owner_ff[i] <= '0;
         end
         head_ff <= NULL_LINK;
         tail_ff <= NULL_LINK;
         size_ff <= '0;
      end else if (fire) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         size_ff <= size_in;
         if (wr_pn) begin
            prev_ff[pn_addr] <= pn_val;
         end
         if (wr_nn) begin
            next_ff[nn_addr] <= nn_val;
         end
         if (wr_self) begin
            prev_ff[sidx]  <= self_prev;
            next_ff[sidx]  <= self_next;
            owner_ff[sidx] <= self_owner;
         end
      end
   end

   // Data bytes, written on append only
   always_ff @(posedge clock) begin
      if (fire && wr_data) begin
         data_ff[sidx] <= op.payload;
      end
   end

   `ASSERT_ALWAYS(a_head_empty, clock, reset,
      (size_ff == '0) == (head_ff == NULL_LINK), "head pointer disagrees with list size")
   `ASSERT_ALWAYS(a_size_max, clock, reset,
      size_ff <= CNT_W'(SLOTS), "list size exceeds slot pool")
   `ASSERT_NEXT(a_append_grows, clock, reset,
      fire && op.func == FUNC_APPEND && status == ST_OK,
      size_ff == $past(size_ff) + 1'b1, "accepted append did not grow the list")

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Checks the linked list queue manager against a behavioral list tracker.
// Directed beats walk the empty, only-entry, head, middle and tail removes
// and every refusal; random beats then fill and drain the slot pool toward
// moving target depths, with some malformed beats mixed in. Both channels
// idle in short random bursts, except near the end of the run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import lqm_pkg::*;

   localparam int RANDOM_OPS  = 700;
   localparam int QUIET_AFTER = 550;   // no idling from this beat on
   localparam int STALL_LIMIT = 500;   // cycles without any handshake
   localparam int DRAIN_WAIT  = 8;

   // -------------------------------------------------------------------------
   // List tracker: predicts each response and holds the ones still due
   // -------------------------------------------------------------------------
   class list_tracker;
      logic [LINK_W-1:0]   prev_of [SLOTS];
      logic [LINK_W-1:0]   next_of [SLOTS];
      logic [TAG_BITS-1:0] owner_of[SLOTS];
      logic [DATA_W-1:0]   data_of [SLOTS];
      logic [LINK_W-1:0]   head_slot;
      logic [LINK_W-1:0]   tail_slot;
      logic [CNT_W-1:0]    depth;
      rsp_type             expected_rsp[$];
      int                  errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            prev_of[i]  = NULL_LINK;
            next_of[i]  = NULL_LINK;
            owner_of[i] = '0;
            data_of[i]  = '0;
         end
         head_slot = NULL_LINK;
         tail_slot = NULL_LINK;
         depth     = '0;
         errors    = 0;
      endfunction

      // Apply one accepted request beat and queue the response it causes
      function void apply_op(op_type op);
         rsp_type             rsp;
         logic [TAG_BITS-1:0] owner;
         logic [SLOT_W-1:0]   s;
         logic [LINK_W-1:0]   p;
         logic [LINK_W-1:0]   n;
         bit                  in_range;
         owner    = op.tag[TAG_BITS-1:0];
         in_range = int'(op.slot) < SLOTS;
         s        = op.slot[SLOT_W-1:0];
         rsp.removed_data = ERR_DATA;
         if (op.func == FUNC_APPEND) begin
            if (!in_range || owner == '0 || owner_of[s] != '0) begin
               rsp.status = ST_REFUSED;
            end else begin
               rsp.status  = ST_OK;
               data_of[s]  = op.payload;
               owner_of[s] = owner;
               next_of[s]  = NULL_LINK;
               if (depth == '0 || tail_slot == NULL_LINK) begin
                  prev_of[s] = NULL_LINK;
                  head_slot  = LINK_W'(s);
               end else begin
                  prev_of[s] = tail_slot;
                  next_of[tail_slot[SLOT_W-1:0]] = LINK_W'(s);
               end
               tail_slot = LINK_W'(s);
               depth++;
            end
         end else if (depth == '0) begin
            rsp.status = ST_EMPTY;
         end else if (!in_range || owner_of[s] == '0) begin
            rsp.status = ST_UNLINKED;
         end else begin
            rsp.status = ST_OK;
            p = prev_of[s];
            n = next_of[s];
            // unlink: only entry, head, tail or middle
            if (depth == CNT_W'(1)) begin
               head_slot = NULL_LINK;
               tail_slot = NULL_LINK;
            end else if (LINK_W'(s) == head_slot) begin
               head_slot = n;
               if (n != NULL_LINK) prev_of[n[SLOT_W-1:0]] = NULL_LINK;
            end else if (LINK_W'(s) == tail_slot) begin
               tail_slot = p;
               if (p != NULL_LINK) next_of[p[SLOT_W-1:0]] = NULL_LINK;
            end else begin
               if (n != NULL_LINK) prev_of[n[SLOT_W-1:0]] = p;
               if (p != NULL_LINK) next_of[p[SLOT_W-1:0]] = n;
            end
            depth--;
            rsp.removed_data = data_of[s];
            prev_of[s]  = NULL_LINK;
            next_of[s]  = NULL_LINK;
            owner_of[s] = '0;
         end
         rsp.count      = depth;
         rsp.first_slot = head_slot;
         expected_rsp.push_back(rsp);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Check one accepted response beat against the oldest prediction
      function void check_rsp(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: expected nothing, actual %p",
                     $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("status", int'(want.status), int'(got.status));
         compare_field("removed_data", int'(want.removed_data), int'(got.removed_data));
         compare_field("count", int'(want.count), int'(got.count));
         compare_field("first_slot", int'(want.first_slot), int'(got.first_slot));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block ports
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = 1'b0;
   logic [SLOT_IN_W-1:0] req_slot = '0;
   logic [DATA_W-1:0]    req_payload = '0;
   logic [TAG_IN_W-1:0]  req_tag = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [DATA_W-1:0]    rsp_removed_data;
   logic [CNT_W-1:0]     rsp_count;
   logic [LINK_W-1:0]    rsp_first_slot;

   list_tracker tracker = new();
   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   linked_list_queue_manager u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_payload      (req_payload),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_removed_data (rsp_removed_data),
      .rsp_count        (rsp_count),
      .rsp_first_slot   (rsp_first_slot)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Response side: check accepted beats, stall in random bursts
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status       = status_type'(rsp_status);
         got.removed_data = rsp_removed_data;
         got.count        = rsp_count;
         got.first_slot   = rsp_first_slot;
         tracker.check_rsp(got);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any handshake ends the run
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Drive one beat, optionally after an idle burst, and return at its accept
   task automatic send_op(input op_type op);
      int gap;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= op.func;
      req_slot    <= op.slot;
      req_payload <= op.payload;
      req_tag     <= op.tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.apply_op(op);
   endtask

   task automatic send_fields(input func_type f, input int s, input int p, input int t);
      op_type op;
      op.func    = f;
      op.slot    = SLOT_IN_W'(s);
      op.payload = DATA_W'(p);
      op.tag     = TAG_IN_W'(t);
      send_op(op);
   endtask

   // Hold off new beats until every predicted response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Random slot that is linked (or free); any slot if none qualifies
   function automatic logic [SLOT_IN_W-1:0] pick_slot(input bit linked);
      logic [SLOT_IN_W-1:0] cand[$];
      for (int i = 0; i < SLOTS; i++) begin
         if ((tracker.owner_of[i] != '0) == linked) cand.push_back(SLOT_IN_W'(i));
      end
      if (cand.size() == 0) return SLOT_IN_W'($urandom_range(0, SLOTS - 1));
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   initial begin
      op_type op;
      int     target_depth;
      bit     grow;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: refusals, extremes and each unlink position
      send_fields(FUNC_REMOVE, 0, 8'h00, 7);     // remove from empty list
      send_fields(FUNC_APPEND, 3, 8'h12, 0);     // owner none
      send_fields(FUNC_APPEND, 0, 8'h00, 7);
      send_fields(FUNC_REMOVE, 0, 8'h00, 0);     // only entry
      send_fields(FUNC_APPEND, 0, 8'hFF, 1);
      send_fields(FUNC_APPEND, 15, 8'h00, 7);
      send_fields(FUNC_APPEND, 15, 8'h33, 2);    // already linked
      send_fields(FUNC_REMOVE, 9, 8'hFF, 7);     // unowned slot
      send_fields(FUNC_APPEND, 5, 8'hA5, 3);
      send_fields(FUNC_APPEND, 10, 8'h5A, 4);
      send_fields(FUNC_REMOVE, 15, 8'h00, 0);    // middle
      send_fields(FUNC_REMOVE, 0, 8'h00, 0);     // head
      send_fields(FUNC_REMOVE, 10, 8'h00, 0);    // tail
      send_fields(FUNC_APPEND, 10, 8'h77, 6);
      send_fields(FUNC_REMOVE, 10, 8'h00, 0);    // tail with one left
      send_fields(FUNC_REMOVE, 5, 8'h00, 0);     // only entry
      send_fields(FUNC_REMOVE, 5, 8'h00, 0);     // empty again
      wait_idle();

      // random: fill and drain toward moving target depths, some noise
      target_depth = SLOTS;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == RANDOM_OPS / 2) wait_idle();
         if (n == QUIET_AFTER) idle_on = 1'b0;
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: target_depth = 0;
               1: target_depth = SLOTS;
               default: target_depth = $urandom_range(0, SLOTS);
            endcase
         end
         op.payload = DATA_W'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            op.func = func_type'($urandom_range(0, 1));
            op.slot = SLOT_IN_W'($urandom);
            op.tag  = TAG_IN_W'($urandom);
         end else begin
            if (int'(tracker.depth) < target_depth) grow = 1'b1;
            else if (int'(tracker.depth) > target_depth) grow = 1'b0;
            else grow = $urandom_range(0, 1);
            if (int'(tracker.depth) == 0) grow = 1'b1;
            if (int'(tracker.depth) == SLOTS) grow = 1'b0;
            op.func = grow ? FUNC_APPEND : FUNC_REMOVE;
            op.slot = pick_slot(!grow);
            op.tag  = TAG_IN_W'($urandom_range(1, (1 << TAG_IN_W) - 1));
         end
         send_op(op);
      end
      req_valid <= 1'b0;

      // drain
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
